// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the box pixel classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define BPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// Types and constants of the box pixel classifier.
package bpc_pkg;

   // Bounds and scaled samples in Q16.8.
   localparam int BOUND_W = 24;
   localparam int SAMPLE_W = 16;
   localparam int FRAC_W = 8;
   localparam int LABEL_W = 4;
   localparam int CLASS_IDX_W = 4;
   localparam int CHAN_IDX_W = 3;

   typedef logic signed [BOUND_W-1:0] bound_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [LABEL_W-1:0] label_type;

   // Item kinds carried in req_tuser.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   // Bound select codes.
   localparam logic BOUND_LOW = 1'b0;
   localparam logic BOUND_HIGH = 1'b1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_LIMIT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS = 4'd1;
   localparam int CLASS_LIMIT_W = 5;
   localparam int NUM_CHANNELS_W = 4;
   localparam logic [CLASS_LIMIT_W-1:0] CLASS_LIMIT_RESET = 5'd16;
   localparam logic [NUM_CHANNELS_W-1:0] NUM_CHANNELS_RESET = 4'd1;

   // Control of the compare stage.
   typedef struct packed {
      logic valid;
      logic last_chan;
   } s1_type;

endpackage

// ===== rtl/box_pixel_classifier.sv =====
// Box pixel classifier: top level with stream ports, bound lanes and result register.
// The result of a pixel's last channel is registered after the bound read and compare stage.
// Throughput: one item per cycle, loads and samples alike, while the compare stage is not
// stalled; the registered bound read and one compare stage per class lane run in parallel.
// Reset: synchronous, active high; sets all marks, clears channel position, the stages and
// restores class limit 16, num_channels 1. Bound memories stay unknown until written.
module box_pixel_classifier #(
   parameter int CLASS_COUNT = 16,
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] class_index, [6:4] channel_index, [7] bound_select,
   // [31:8] bound_value, [47:32] sample
   input  logic [47:0]                     req_tdata,
   // [0] mode
   input  logic [0:0]                      req_tuser,
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] class_label, [7:4] zero
   output logic [7:0]                      rsp_tdata,
   // [0] matched
   output logic [0:0]                      rsp_tuser,
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bpc_pkg::*;

   localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   // Configuration registers.
   logic [CLASS_LIMIT_W-1:0]  class_limit_ff;
   logic [NUM_CHANNELS_W-1:0] num_channels_ff;

   // Unpacked input fields.
   logic                      in_mode;
   logic [CLASS_IDX_W-1:0]    in_class;
   logic [CHAN_IDX_W-1:0]     in_chan;
   logic                      in_bsel;
   bound_type                 in_bound;
   sample_type                in_sample;

   logic                      req_accept;
   logic                      load_accept;
   logic                      sample_accept;
   logic                      load_chan_ok;
   logic                      last_chan;

   // Channel position of the next sample.
   logic [CH_W-1:0]           pos_ff;
   logic [CH_W-1:0]           pos_in;

   // Compare stage.
   s1_type                    s1_ff;
   s1_type                    s1_in;
   bound_type                 s1_sample_ff;
   logic                      s1_fire;

   logic [CLASS_COUNT-1:0]    hit;
   logic [CLASS_COUNT-1:0]    enable;
   label_type                 vote_label;
   logic                      vote_matched;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   label_type                 rsp_label_ff;
   logic                      rsp_matched_ff;

   assign in_mode   = req_tuser[0];
   assign in_class  = req_tdata[3:0];
   assign in_chan   = req_tdata[6:4];
   assign in_bsel   = req_tdata[7];
   assign in_bound  = req_tdata[31:8];
   assign in_sample = req_tdata[47:32];

   // Configuration: always ready; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_limit_ff  <= CLASS_LIMIT_RESET;
         num_channels_ff <= NUM_CHANNELS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLASS_LIMIT:  class_limit_ff  <= csr_data[CLASS_LIMIT_W-1:0];
            CSR_NUM_CHANNELS: num_channels_ff <= csr_data[NUM_CHANNELS_W-1:0];
            default: ;
         endcase
      end
   end

   // Class 0 is always tested (a zero count counts as one); the class limit caps the rest.
   always_comb begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
         enable[c] = (c == 0) || (32'(c) < 32'(class_limit_ff));
      end
   end

   // The compare stage moves on unless it ends a pixel and the result register is full and not read.
   assign s1_fire    = s1_ff.valid && (!s1_ff.last_chan || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_ff.valid || s1_fire;

   assign req_accept    = req_tvalid && req_tready;
   assign load_accept   = req_accept && (in_mode == MODE_LOAD);
   assign sample_accept = req_accept && (in_mode == MODE_SAMPLE);
   assign load_chan_ok  = 32'(in_chan) < CHANNEL_COUNT;

   // A sample at or past the last configured channel ends the pixel.
   assign last_chan = (32'(pos_ff) + 32'd1 >= 32'(num_channels_ff))
                   || (32'(pos_ff) + 32'd1 >= CHANNEL_COUNT);

   always_comb begin
      pos_in = pos_ff;
      if (sample_accept) begin
         pos_in = last_chan ? '0 : CH_W'(32'(pos_ff) + 32'd1);
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (req_tready) begin
         s1_in.valid     = sample_accept;
         s1_in.last_chan = last_chan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         s1_ff  <= '0;
      end else begin
         pos_ff <= pos_in;
         s1_ff  <= s1_in;
      end
   end

   // Scale the sample to Q16.8 on the way in.
   always_ff @(posedge clock) begin
      if (sample_accept) begin
         s1_sample_ff <= {in_sample, {FRAC_W{1'b0}}};
      end
   end

   // One lane per class, all read at the current channel in parallel.
   for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_lane
      logic lane_sel;

      assign lane_sel = load_accept && load_chan_ok && (32'(in_class) == g);

      bpc_lane #(
         .CHANNEL_COUNT (CHANNEL_COUNT)
      ) u_lane (
         .clock     (clock),
         .wr_lo     (lane_sel && (in_bsel == BOUND_LOW)),
         .wr_hi     (lane_sel && (in_bsel == BOUND_HIGH)),
         .wr_addr   (CH_W'(in_chan)),
         .wr_data   (in_bound),
         .rd_en     (sample_accept),
         .rd_addr   (pos_ff),
         .s1_sample (s1_sample_ff),
         .hit       (hit[g])
      );
   end

   bpc_vote #(
      .CLASS_COUNT (CLASS_COUNT)
   ) u_vote (
      .clock   (clock),
      .reset   (reset),
      .s1      (s1_ff),
      .fire    (s1_fire),
      .hit     (hit),
      .enable  (enable),
      .label   (vote_label),
      .matched (vote_matched)
   );

   // Result register: load on the last channel, drop once transferred.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_fire && s1_ff.last_chan) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.last_chan) begin
         rsp_label_ff   <= vote_label;
         rsp_matched_ff <= vote_matched;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - LABEL_W){1'b0}}, rsp_label_ff};
   assign rsp_tuser  = rsp_matched_ff;

endmodule

// ===== rtl/bpc_lane.sv =====
// One class lane: bound memories per channel and the box test on a sample.
module bpc_lane #(
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 wr_lo,
   input  logic                 wr_hi,
   input  logic [((CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1)-1:0] wr_addr,
   input  bpc_pkg::bound_type   wr_data,
   input  logic                 rd_en,
   input  logic [((CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1)-1:0] rd_addr,
   input  bpc_pkg::bound_type   s1_sample,
   output logic                 hit
);
   import bpc_pkg::*;

   bound_type lo_mem [CHANNEL_COUNT];
   bound_type hi_mem [CHANNEL_COUNT];
   bound_type lo_q_ff;
   bound_type hi_q_ff;

   always_ff @(posedge clock) begin
      if (wr_lo) begin
         lo_mem[wr_addr] <= wr_data;
      end
      if (wr_hi) begin
         hi_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         lo_q_ff <= lo_mem[rd_addr];
         hi_q_ff <= hi_mem[rd_addr];
      end
   end

   // Half-open box: low inclusive, high exclusive.
   assign hit = (s1_sample >= lo_q_ff) && (s1_sample < hi_q_ff);

endmodule

// ===== rtl/bpc_vote.sv =====
// Match marks across the channels of a pixel and the highest-class pick.
module bpc_vote #(
   parameter int CLASS_COUNT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bpc_pkg::s1_type        s1,
   input  logic                   fire,
   input  logic [CLASS_COUNT-1:0] hit,
   input  logic [CLASS_COUNT-1:0] enable,
   output bpc_pkg::label_type     label,
   output logic                   matched
);
   import bpc_pkg::*;

   logic [CLASS_COUNT-1:0] marks_ff;
   logic [CLASS_COUNT-1:0] marks_in;
   logic [CLASS_COUNT-1:0] surviving;

   // Disabled classes keep their mark; enabled ones drop it on a miss.
   assign surviving = marks_ff & hit & enable;

   always_comb begin
      marks_in = marks_ff;
      if (fire) begin
         if (s1.last_chan) begin
            marks_in = '1;
         end else begin
            marks_in = marks_ff & (hit | ~enable);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '1;
      end else begin
         marks_ff <= marks_in;
      end
   end

   // Highest surviving class wins; label keeps its low bits only.
   always_comb begin
      label = '0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
         if (surviving[c]) begin
            label = LABEL_W'(c);
         end
      end
   end

   assign matched = |surviving;

endmodule

// ===== rtl/bpc_checker.sv =====
// Port-level checks on the box pixel classifier, bound to the top level.
`include "assert_macros.svh"

module bpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser
);

   `BPC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `BPC_ASSERT(a_nomatch_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0, "label not zero without a match")

   `BPC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind box_pixel_classifier bpc_checker u_bpc_checker (.*);
